/* hdl/spr_pkg.sv */
package spr_pkg;

   // frame constants
   localparam logic [15:0] CRC_POLY   = 16'h8005;
   localparam logic [7:0]  SYNC_BYTE  = 8'hFF;
   localparam logic [7:0]  STUFF_BYTE = 8'hFD;
   localparam logic [7:0]  RSRV_BYTE  = 8'h00;
   localparam logic [16:0] POS_MAX    = 17'h1FFFF;

   // frame status codes
   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_BAD_HEADER = 2'd1,
      STATUS_BAD_LENGTH = 2'd2,
      STATUS_BAD_CRC    = 2'd3
   } status_type;

   // one received request
   typedef struct packed {
      logic [7:0] rx_byte;
      logic       frame_end;
   } req_item_type;

   // input register contents
   typedef struct packed {
      logic         valid;
      req_item_type item;
   } stage_type;

   // one result
   typedef struct packed {
      logic        is_status;
      logic [7:0]  param_byte;
      logic [15:0] param_index;
      logic [1:0]  status_code;
      logic [7:0]  servo_id;
      logic [7:0]  instruction_code;
      logic [15:0] param_count;
   } rsp_item_type;

   // expected header byte at positions 0 to 3
   function automatic logic [7:0] hdr_byte(input logic [1:0] idx);
      logic [7:0] val;
      unique case (idx)
         2'd0:    val = SYNC_BYTE;
         2'd1:    val = SYNC_BYTE;
         2'd2:    val = STUFF_BYTE;
         default: val = RSRV_BYTE;
      endcase
      return val;
   endfunction

   // crc-16 one byte update, msb first, no reflection
   function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

/* hdl/spr_stream_if.sv */
// request channel: one received byte per transfer
interface spr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       frame_end;

   modport source (output valid, output rx_byte, output frame_end, input ready);
   modport sink   (input valid, input rx_byte, input frame_end, output ready);
endinterface

// result channel: parameter byte or frame status
interface spr_rsp_if;
   logic        valid;
   logic        ready;
   logic        is_status;
   logic [7:0]  param_byte;
   logic [15:0] param_index;
   logic [1:0]  status_code;
   logic [7:0]  servo_id;
   logic [7:0]  instruction_code;
   logic [15:0] param_count;

   modport source (output valid, output is_status, output param_byte, output param_index,
                   output status_code, output servo_id, output instruction_code,
                   output param_count, input ready);
   modport sink   (input valid, input is_status, input param_byte, input param_index,
                   input status_code, input servo_id, input instruction_code,
                   input param_count, output ready);
endinterface

/* hdl/spr_input_stage.sv */
module spr_input_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  spr_pkg::req_item_type in_item,
   input  logic                  take,
   output spr_pkg::stage_type    stage
);

   logic                  valid_ff, valid_in;
   spr_pkg::req_item_type item_ff;

   // register refills when empty or when its request moves on
   assign in_ready = !valid_ff || take;

   always_comb begin
      valid_in = valid_ff;
      if (in_valid && in_ready) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_valid && in_ready) begin
         item_ff <= in_item;
      end
   end

   assign stage.valid = valid_ff;
   assign stage.item  = item_ff;

endmodule

/* hdl/spr_frame_parser.sv */
module spr_frame_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  spr_pkg::stage_type    stage,
   output logic                  take,
   output logic                  out_valid,
   input  logic                  out_ready,
   output spr_pkg::rsp_item_type out_item
);

   typedef enum logic [1:0] {
      MATCH_NONE   = 2'd0,
      MATCH_FF     = 2'd1,
      MATCH_FFFF   = 2'd2,
      MATCH_FFFFFD = 2'd3
   } match_type;

   logic [16:0] pos_ff, pos_in;
   logic [15:0] len_ff, len_in;
   logic [15:0] crc_ff, crc_in;
   logic [15:0] rcrc_ff, rcrc_in;
   logic        hdr_ok_ff, hdr_ok_in;
   match_type   match_ff, match_in;
   logic [7:0]  id_ff, id_in;
   logic [7:0]  instr_ff, instr_in;
   logic [15:0] emitted_ff, emitted_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   spr_pkg::rsp_item_type rsp_item_ff, rsp_item_in;

   logic [7:0]  b;
   logic        fend;
   logic [16:0] len_p5, len_p6;
   logic        region;
   logic        emit;
   match_type   match_nx;
   spr_pkg::status_type code;

   assign b    = stage.item.rx_byte;
   assign fend = stage.item.frame_end;

   // result register frees up when empty or taken
   assign take = stage.valid && (!rsp_valid_ff || out_ready);

   // stuffing matcher on the pre-removal byte stream
   always_comb begin
      if (b == spr_pkg::SYNC_BYTE) begin
         match_nx = (match_ff == MATCH_FF || match_ff == MATCH_FFFF) ? MATCH_FFFF : MATCH_FF;
      end else if (b == spr_pkg::STUFF_BYTE && match_ff == MATCH_FFFF) begin
         match_nx = MATCH_FFFFFD;
      end else begin
         match_nx = MATCH_NONE;
      end
   end

   // per-byte frame update
   always_comb begin
      pos_in     = (pos_ff != spr_pkg::POS_MAX) ? pos_ff + 17'd1 : pos_ff;
      len_in     = len_ff;
      crc_in     = crc_ff;
      rcrc_in    = rcrc_ff;
      hdr_ok_in  = hdr_ok_ff;
      match_in   = match_ff;
      id_in      = id_ff;
      instr_in   = instr_ff;
      emitted_in = emitted_ff;
      emit       = 1'b0;

      // header, id and length fields
      if (pos_ff < 17'd4) begin
         if (b != spr_pkg::hdr_byte(pos_ff[1:0])) begin
            hdr_ok_in = 1'b0;
         end
      end else if (pos_ff == 17'd4) begin
         id_in = b;
      end else if (pos_ff == 17'd5) begin
         len_in = {8'h00, b};
      end else if (pos_ff == 17'd6) begin
         len_in = {b, len_ff[7:0]};
      end

      len_p5 = {1'b0, len_in} + 17'd5;
      len_p6 = {1'b0, len_in} + 17'd6;

      // crc over everything before the crc field
      if (pos_ff < 17'd7 || pos_ff < len_p5) begin
         crc_in = spr_pkg::crc_update(crc_ff, b);
      end

      region = (pos_ff >= 17'd7) && (len_in >= 16'd3) && (pos_ff < len_p5);

      // instruction/parameter area with stuffing removal, then crc field
      if (region) begin
         if (pos_ff == 17'd7) begin
            instr_in = b;
         end
         if (match_ff == MATCH_FFFFFD && b == spr_pkg::STUFF_BYTE) begin
            match_in = MATCH_NONE;
         end else begin
            if (pos_ff > 17'd7 && hdr_ok_in) begin
               emit       = 1'b1;
               emitted_in = emitted_ff + 16'd1;
            end
            match_in = match_nx;
         end
      end else if (pos_ff >= 17'd7 && pos_ff == len_p5) begin
         rcrc_in = {rcrc_ff[15:8], b};
      end else if (pos_ff >= 17'd7 && pos_ff == len_p6) begin
         rcrc_in = {b, rcrc_ff[7:0]};
      end

      // status priority: header, length, crc
      if (!hdr_ok_in) begin
         code = spr_pkg::STATUS_BAD_HEADER;
      end else if (len_in < 16'd3 || pos_ff != len_p6) begin
         code = spr_pkg::STATUS_BAD_LENGTH;
      end else if (crc_in != rcrc_in) begin
         code = spr_pkg::STATUS_BAD_CRC;
      end else begin
         code = spr_pkg::STATUS_OK;
      end

      // result assembly
      rsp_item_in = '0;
      if (fend) begin
         rsp_item_in.is_status        = 1'b1;
         rsp_item_in.status_code      = code;
         rsp_item_in.servo_id         = id_in;
         rsp_item_in.instruction_code = instr_in;
         rsp_item_in.param_count      = emitted_in;
      end else begin
         rsp_item_in.param_byte  = b;
         rsp_item_in.param_index = emitted_ff;
      end

      rsp_valid_in = rsp_valid_ff && !out_ready;
      if (take) begin
         rsp_valid_in = fend || emit;
      end

      // frame end clears the frame state
      if (fend) begin
         pos_in     = '0;
         len_in     = '0;
         crc_in     = '0;
         rcrc_in    = '0;
         hdr_ok_in  = 1'b1;
         match_in   = MATCH_NONE;
         id_in      = '0;
         instr_in   = '0;
         emitted_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         len_ff       <= '0;
         crc_ff       <= '0;
         rcrc_ff      <= '0;
         hdr_ok_ff    <= 1'b1;
         match_ff     <= MATCH_NONE;
         id_ff        <= '0;
         instr_ff     <= '0;
         emitted_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            pos_ff     <= pos_in;
            len_ff     <= len_in;
            crc_ff     <= crc_in;
            rcrc_ff    <= rcrc_in;
            hdr_ok_ff  <= hdr_ok_in;
            match_ff   <= match_in;
            id_ff      <= id_in;
            instr_ff   <= instr_in;
            emitted_ff <= emitted_in;
         end
      end
      if (take) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign out_valid = rsp_valid_ff;
   assign out_item  = rsp_item_ff;

endmodule

/* hdl/servo_packet_receive_parser.sv */
// channel     port      direction  payload
// request     req_port  in         rx_byte, frame_end
// result      rsp_port  out        is_status, param_byte, param_index, status_code,
//                                  servo_id, instruction_code, param_count
//
// One received byte per cycle while the result is not stalled: each request
// passes an input register, then crc and matcher logic into the result register.
// A request yields at most one result; a status result closes each frame.
// Synchronous active-high reset clears all frame state.
// A stalled result holds; the input register keeps taking requests until full.
module servo_packet_receive_parser (
   input logic     clock,
   input logic     reset,
   spr_req_if.sink   req_port,
   spr_rsp_if.source rsp_port
);

   spr_pkg::req_item_type req_item;
   spr_pkg::stage_type    stage;
   spr_pkg::rsp_item_type rsp_item;
   logic                  take;

   assign req_item.rx_byte   = req_port.rx_byte;
   assign req_item.frame_end = req_port.frame_end;

   // input register
   spr_input_stage u_input (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_port.valid),
      .in_ready (req_port.ready),
      .in_item  (req_item),
      .take     (take),
      .stage    (stage)
   );

   // frame state and result register
   spr_frame_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .stage     (stage),
      .take      (take),
      .out_valid (rsp_port.valid),
      .out_ready (rsp_port.ready),
      .out_item  (rsp_item)
   );

   assign rsp_port.is_status        = rsp_item.is_status;
   assign rsp_port.param_byte       = rsp_item.param_byte;
   assign rsp_port.param_index      = rsp_item.param_index;
   assign rsp_port.status_code      = rsp_item.status_code;
   assign rsp_port.servo_id         = rsp_item.servo_id;
   assign rsp_port.instruction_code = rsp_item.instruction_code;
   assign rsp_port.param_count      = rsp_item.param_count;

endmodule
